// ----- rtl/lpg_pkg.sv -----
`default_nettype none

package lpg_pkg;

    typedef logic [7:0] t_mode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       link_alive;
    } t_result;

    localparam logic [7:0] CFG_STATION_ID = 8'd0;
    localparam logic [7:0] CFG_ALARM_CODE = 8'd1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    localparam t_mode MODE_BREATHE_RED     = 8'd1;
    localparam t_mode MODE_BREATHE_GREEN   = 8'd2;
    localparam t_mode MODE_BLINK_GREEN     = 8'd3;
    localparam t_mode MODE_BREATHE_CYAN    = 8'd4;
    localparam t_mode MODE_BREATHE_YELLOW  = 8'd5;
    localparam t_mode MODE_BLINK_MAGENTA   = 8'd6;
    localparam t_mode MODE_BLINK_YELLOW    = 8'd7;
    localparam t_mode MODE_BREATHE_MAGENTA = 8'd8;

    localparam logic [7:0]  DIM_TOP      = 8'd254;
    localparam logic [7:0]  DIM_BOTTOM   = 8'd1;
    localparam logic [15:0] BLINK_ON_MS  = 16'd200;
    localparam logic [15:0] BLINK_END_MS = 16'd300;
    localparam logic [15:0] FAST_STEP_MS = 16'd1;
    localparam logic [15:0] SLOW_STEP_MS = 16'd10;
    localparam logic [15:0] PHASE_MAX    = 16'hFFFF;
    localparam logic [10:0] LINK_MAX     = 11'h7FF;
    localparam logic [10:0] LINK_TIMEOUT = 11'd1000;

endpackage

`default_nettype wire

// ----- rtl/led_pattern_generator_core.sv -----
// Drives one RGB colour and a link-alive flag from a stream of items. An
// input item is either a one millisecond tick (opcode 0) or a received
// command frame (opcode 1, with target and value bytes). Every accepted item
// gives exactly one result item carrying the colour and the link flag.
//
// Both channels use valid/stall: an item moves on a rising edge where valid
// is high and stall is low. The configuration port (valid/ready, index, data)
// writes the station id (index 0) and the alarm reset code (index 1); it is
// always ready and other indexes are ignored.
//
// Throughput is one item per cycle while o_in_stall is low; the state
// update is a single combinational pass from the state registers. A
// one-entry skid stage lets an item be taken while a result waits, so
// o_in_stall rises only when both the output register and the skid entry
// are full under i_out_stall.
//
// Synchronous active-low reset clears the mode, counters, colour and
// station registers, sets the dimmer direction to rising and empties both
// the output register and the skid entry.
`default_nettype none

module led_pattern_generator_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,

    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_frame_target,
    input  wire logic [7:0] i_frame_value,

    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic            o_link_alive
);
    import lpg_pkg::*;

    logic [7:0]  r_station_id;
    logic [7:0]  r_alarm_code;

    t_mode       r_light_mode,    n_light_mode;
    logic [15:0] r_phase_elapsed, n_phase_elapsed;
    logic [7:0]  r_dimmer_level,  n_dimmer_level;
    logic        r_rising,        n_rising;
    logic [10:0] r_link_elapsed,  n_link_elapsed;
    logic [7:0]  r_red,           n_red;
    logic [7:0]  r_green,         n_green;
    logic [7:0]  r_blue,          n_blue;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        accept;
    logic        out_free;
    t_result     result;

    logic [15:0] phase_tick;
    logic [15:0] step_limit;
    logic        step;
    logic        step_rising;
    logic [7:0]  step_level;
    logic        breathe;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    // event then mode logic
    always_comb begin
        n_light_mode   = r_light_mode;
        n_link_elapsed = r_link_elapsed;
        phase_tick     = r_phase_elapsed;
        if (i_opcode == OP_TICK) begin
            if (r_phase_elapsed < PHASE_MAX)
                phase_tick = r_phase_elapsed + 16'd1;
            if (r_link_elapsed < LINK_MAX)
                n_link_elapsed = r_link_elapsed + 11'd1;
        end else if (i_frame_target == r_station_id) begin
            n_link_elapsed = '0;
            if (i_frame_value != r_alarm_code)
                n_light_mode = i_frame_value;
        end

        step_limit  = (n_light_mode == MODE_BREATHE_RED) ? FAST_STEP_MS : SLOW_STEP_MS;
        step        = phase_tick > step_limit;
        if (r_dimmer_level >= DIM_TOP)
            step_rising = 1'b0;
        else if (r_dimmer_level <= DIM_BOTTOM)
            step_rising = 1'b1;
        else
            step_rising = r_rising;
        step_level  = step_rising ? r_dimmer_level + 8'd1 : r_dimmer_level - 8'd1;

        n_phase_elapsed = phase_tick;
        n_dimmer_level  = r_dimmer_level;
        n_rising        = r_rising;
        n_red           = r_red;
        n_green         = r_green;
        n_blue          = r_blue;
        breathe         = 1'b0;

        unique case (n_light_mode)
            MODE_BREATHE_RED, MODE_BREATHE_GREEN, MODE_BREATHE_CYAN,
            MODE_BREATHE_YELLOW, MODE_BREATHE_MAGENTA: begin
                breathe = step;
            end
            MODE_BLINK_GREEN, MODE_BLINK_MAGENTA, MODE_BLINK_YELLOW: begin
                if (phase_tick < BLINK_ON_MS) begin
                    n_red   = (n_light_mode == MODE_BLINK_GREEN) ? 8'd0 : DIM_TOP;
                    n_green = (n_light_mode == MODE_BLINK_MAGENTA) ? 8'd0 : DIM_TOP;
                    n_blue  = (n_light_mode == MODE_BLINK_MAGENTA) ? DIM_TOP : 8'd0;
                end
                if (phase_tick > BLINK_ON_MS && phase_tick < BLINK_END_MS) begin
                    n_red   = '0;
                    n_green = '0;
                    n_blue  = '0;
                end
                if (phase_tick > BLINK_END_MS)
                    n_phase_elapsed = '0;
            end
            default: begin
            end
        endcase

        if (breathe) begin
            n_phase_elapsed = '0;
            n_rising        = step_rising;
            n_dimmer_level  = step_level;
            n_red   = (n_light_mode == MODE_BREATHE_RED || n_light_mode == MODE_BREATHE_YELLOW
                       || n_light_mode == MODE_BREATHE_MAGENTA) ? step_level : 8'd0;
            n_green = (n_light_mode == MODE_BREATHE_GREEN || n_light_mode == MODE_BREATHE_CYAN
                       || n_light_mode == MODE_BREATHE_YELLOW) ? step_level : 8'd0;
            n_blue  = (n_light_mode == MODE_BREATHE_CYAN
                       || n_light_mode == MODE_BREATHE_MAGENTA) ? step_level : 8'd0;
        end

        result.red        = n_red;
        result.green      = n_green;
        result.blue       = n_blue;
        result.link_alive = n_link_elapsed <= LINK_TIMEOUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id    <= '0;
            r_alarm_code    <= '0;
            r_light_mode    <= '0;
            r_phase_elapsed <= '0;
            r_dimmer_level  <= '0;
            r_rising        <= 1'b1;
            r_link_elapsed  <= '0;
            r_red           <= '0;
            r_green         <= '0;
            r_blue          <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_STATION_ID)
                    r_station_id <= i_cfg_data;
                else if (i_cfg_index == CFG_ALARM_CODE)
                    r_alarm_code <= i_cfg_data;
            end
            if (accept) begin
                r_light_mode    <= n_light_mode;
                r_phase_elapsed <= n_phase_elapsed;
                r_dimmer_level  <= n_dimmer_level;
                r_rising        <= n_rising;
                r_link_elapsed  <= n_link_elapsed;
                r_red           <= n_red;
                r_green         <= n_green;
                r_blue          <= n_blue;
            end
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (accept)
                r_out <= result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red        = r_out.red;
    assign o_green      = r_out.green;
    assign o_blue       = r_out.blue;
    assign o_link_alive = r_out.link_alive;

`ifndef ASSERT_OFF
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid entry full with empty output register");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && i_out_stall) |=> o_in_stall)
        else $error("item taken under stall not held in skid entry");

    a_frame_refreshes_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_FRAME && i_frame_target == r_station_id)
        |=> (r_link_elapsed == 11'd0))
        else $error("addressed frame did not clear the link watchdog");

    a_mode_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_light_mode) && $stable(r_phase_elapsed))
        else $error("state moved without an item");
`endif

endmodule

`default_nettype wire
